// File: hw/rtl/bms_serial_frame_parser_assert.svh
// Assertion macros shared by the serial frame parser RTL.
// Depends on nothing; the macros expand to empty text when SYNTH is defined.
`ifndef BMS_SERIAL_FRAME_PARSER_ASSERT_SVH
`define BMS_SERIAL_FRAME_PARSER_ASSERT_SVH
`ifndef SYNTH
// Implication or plain property checked on every clock edge outside reset.
`define BSFP_ASSERT_IMP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true outside reset.
`define BSFP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BSFP_ASSERT_IMP(lbl, clk, rst_n, prop, msg)
`define BSFP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: hw/rtl/bsfp_pkg.sv
// Shared types, codes and constants of the serial frame parser.
// Used by the interfaces, the controller, the datapath and the top level.
package bsfp_pkg;

  localparam int RX_W       = 8;
  localparam int IDX_W      = 6;
  localparam int FS_W       = 2;
  localparam int PLEN_W     = 7;
  localparam int SUM_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam int MAX_PAYLOAD_DEF = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_START   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMAND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STATUS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_END     = 3'd4;

  // Configuration reset values.
  localparam logic [RX_W-1:0]   START_RST   = 8'd221;
  localparam logic [RX_W-1:0]   COMMAND_RST = 8'd3;
  localparam logic [RX_W-1:0]   STATUS_RST  = 8'd0;
  localparam logic [PLEN_W-1:0] LENGTH_RST  = 7'd27;
  localparam logic [RX_W-1:0]   END_RST     = 8'd119;

  // Frame status codes.
  localparam logic [FS_W-1:0] FS_OK         = 2'd0;
  localparam logic [FS_W-1:0] FS_BAD_END    = 2'd1;
  localparam logic [FS_W-1:0] FS_BAD_CKSUM  = 2'd2;
  localparam logic [FS_W-1:0] FS_DEV_STATUS = 2'd3;

  typedef enum logic [3:0] {
    ST_START,
    ST_CMD,
    ST_STATUS,
    ST_LEN,
    ST_DATA,
    ST_CKHI,
    ST_CKLO,
    ST_END,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            cap_status;
    logic            add_sum;
    logic            clr_count;
    logic            store_data;
    logic            cap_ckhi;
    logic            cap_cklo;
    logic            load_verdict;
    logic [FS_W-1:0] verdict;
    logic            start_emit;
    logic            emit_rd;
    logic            emit_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_match;
    logic cmd_match;
    logic status_match;
    logic len_match;
    logic len_zero;
    logic data_done;
    logic end_match;
    logic cksum_ok;
    logic status_zero;
    logic cnt_zero;
    logic emit_last;
    logic out_free;
  } dp_status_t;

endpackage

// File: hw/rtl/bsfp_if.sv
// Valid/ready channel interfaces of the serial frame parser.
// Depends on bsfp_pkg for the field widths.
interface bsfp_in_if;
  logic                        valid;
  logic                        ready;
  logic [bsfp_pkg::RX_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bsfp_out_if;
  logic                        valid;
  logic                        ready;
  logic [bsfp_pkg::RX_W-1:0]   payload_byte;
  logic [bsfp_pkg::IDX_W-1:0]  byte_index;
  logic [bsfp_pkg::FS_W-1:0]   frame_status;
  logic                        last;

  modport source (output valid, output payload_byte, output byte_index,
                  output frame_status, output last, input ready);
  modport sink   (input valid, input payload_byte, input byte_index,
                  input frame_status, input last, output ready);
endinterface

// File: hw/rtl/bsfp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; used for the payload store.
module bsfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                          clk,
  input  logic                                          wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
  input  logic [WIDTH-1:0]                              wr_data,
  input  logic                                          rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
  output logic [WIDTH-1:0]                              rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/bsfp_ctrl.sv
// Frame state machine of the serial frame parser.
// Depends on bsfp_pkg for the state type and the command/status structs.
module bsfp_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  bsfp_pkg::dp_status_t   status,
  output bsfp_pkg::ctrl_cmd_t    cmd
);

  bsfp_pkg::state_t state_r;
  bsfp_pkg::state_t state_nxt;
  logic             in_fire;

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsfp_pkg::ST_START;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bsfp_pkg::ST_START: begin
        if (in_fire && status.start_match) state_nxt = bsfp_pkg::ST_CMD;
      end
      bsfp_pkg::ST_CMD: begin
        if (in_fire && status.cmd_match) state_nxt = bsfp_pkg::ST_STATUS;
      end
      bsfp_pkg::ST_STATUS: begin
        if (in_fire && status.status_match) state_nxt = bsfp_pkg::ST_LEN;
      end
      bsfp_pkg::ST_LEN: begin
        if (in_fire && status.len_match) begin
          state_nxt = status.len_zero ? bsfp_pkg::ST_CKHI : bsfp_pkg::ST_DATA;
        end
      end
      bsfp_pkg::ST_DATA: begin
        if (in_fire && status.data_done) state_nxt = bsfp_pkg::ST_CKHI;
      end
      bsfp_pkg::ST_CKHI: begin
        if (in_fire) state_nxt = bsfp_pkg::ST_CKLO;
      end
      bsfp_pkg::ST_CKLO: begin
        if (in_fire) state_nxt = bsfp_pkg::ST_END;
      end
      bsfp_pkg::ST_END: begin
        if (in_fire) begin
          if (status.end_match && status.cksum_ok && status.status_zero &&
              !status.cnt_zero) begin
            state_nxt = bsfp_pkg::ST_EMIT_RD;
          end else begin
            state_nxt = bsfp_pkg::ST_START;
          end
        end
      end
      bsfp_pkg::ST_EMIT_RD: begin
        state_nxt = bsfp_pkg::ST_EMIT_LD;
      end
      bsfp_pkg::ST_EMIT_LD: begin
        if (status.out_free) begin
          state_nxt = status.emit_last ? bsfp_pkg::ST_START : bsfp_pkg::ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = bsfp_pkg::ST_START;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      bsfp_pkg::ST_START, bsfp_pkg::ST_CMD: begin
        in_ready = 1'b1;
      end
      bsfp_pkg::ST_STATUS: begin
        in_ready       = 1'b1;
        cmd.cap_status = in_fire && status.status_match;
      end
      bsfp_pkg::ST_LEN: begin
        in_ready      = 1'b1;
        cmd.add_sum   = in_fire && status.len_match;
        cmd.clr_count = in_fire && status.len_match;
      end
      bsfp_pkg::ST_DATA: begin
        in_ready       = 1'b1;
        cmd.add_sum    = in_fire;
        cmd.store_data = in_fire;
      end
      bsfp_pkg::ST_CKHI: begin
        in_ready     = 1'b1;
        cmd.cap_ckhi = in_fire;
      end
      bsfp_pkg::ST_CKLO: begin
        in_ready     = 1'b1;
        cmd.cap_cklo = in_fire;
      end
      bsfp_pkg::ST_END: begin
        // The end byte may produce a verdict, so it waits for a free slot.
        in_ready = status.out_free;
        if (!status.end_match) begin
          cmd.verdict = bsfp_pkg::FS_BAD_END;
        end else if (!status.cksum_ok) begin
          cmd.verdict = bsfp_pkg::FS_BAD_CKSUM;
        end else if (!status.status_zero) begin
          cmd.verdict = bsfp_pkg::FS_DEV_STATUS;
        end else begin
          cmd.verdict = bsfp_pkg::FS_OK;
        end
        cmd.load_verdict = in_fire && (cmd.verdict != bsfp_pkg::FS_OK);
        cmd.start_emit   = in_fire && (cmd.verdict == bsfp_pkg::FS_OK);
      end
      bsfp_pkg::ST_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
      end
      bsfp_pkg::ST_EMIT_LD: begin
        cmd.emit_load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: hw/rtl/bsfp_dp.sv
// Datapath of the serial frame parser: configuration registers, header
// compares, checksum, payload store and the result register. Uses bsfp_pkg and bsfp_ram.
module bsfp_dp #(
  parameter int MAX_PAYLOAD = bsfp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [bsfp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bsfp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [bsfp_pkg::RX_W-1:0]         rx_byte,
  input  bsfp_pkg::ctrl_cmd_t               cmd,
  output bsfp_pkg::dp_status_t              status,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [bsfp_pkg::RX_W-1:0]         out_payload_byte,
  output logic [bsfp_pkg::IDX_W-1:0]        out_byte_index,
  output logic [bsfp_pkg::FS_W-1:0]         out_frame_status,
  output logic                              out_last
);

  localparam int CNT_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CMP_W  = (CNT_W > bsfp_pkg::PLEN_W) ? CNT_W : bsfp_pkg::PLEN_W;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD);
  localparam logic [CMP_W-1:0] CMP_MAX = CMP_W'(MAX_PAYLOAD);

  // Configuration registers.
  logic [bsfp_pkg::RX_W-1:0]   start_r;
  logic [bsfp_pkg::RX_W-1:0]   command_r;
  logic [bsfp_pkg::RX_W-1:0]   exp_status_r;
  logic [bsfp_pkg::PLEN_W-1:0] plen_r;
  logic [bsfp_pkg::RX_W-1:0]   end_r;

  // Frame state.
  logic [CNT_W-1:0]             count_r;
  logic [CNT_W-1:0]             count_nxt;
  logic [CNT_W-1:0]             idx_r;
  logic [CNT_W-1:0]             idx_nxt;
  logic [bsfp_pkg::SUM_W-1:0]   sum_r;
  logic [bsfp_pkg::SUM_W-1:0]   sum_nxt;
  logic [bsfp_pkg::SUM_W-1:0]   cksum_r;
  logic [bsfp_pkg::RX_W-1:0]    status_seen_r;

  // Result register.
  logic                         out_valid_r;
  logic [bsfp_pkg::RX_W-1:0]    out_byte_r;
  logic [bsfp_pkg::IDX_W-1:0]   out_idx_r;
  logic [bsfp_pkg::FS_W-1:0]    out_fs_r;
  logic                         out_last_r;

  logic [CMP_W-1:0]             eff_len;
  logic [CNT_W-1:0]             count_inc;
  logic                         room;
  logic [bsfp_pkg::RX_W-1:0]    ram_rd_data;
  logic                         out_free;

  assign eff_len   = (CMP_W'(plen_r) > CMP_MAX) ? CMP_MAX : CMP_W'(plen_r);
  assign room      = count_r < CNT_MAX;
  assign count_inc = room ? count_r + CNT_W'(1) : count_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    status.start_match  = rx_byte == start_r;
    status.cmd_match    = rx_byte == command_r;
    status.status_match = rx_byte == exp_status_r;
    status.len_match    = rx_byte == bsfp_pkg::RX_W'(plen_r);
    status.len_zero     = plen_r == '0;
    status.data_done    = CMP_W'(count_inc) >= eff_len;
    status.end_match    = rx_byte == end_r;
    status.cksum_ok     = (bsfp_pkg::SUM_W'(0) - sum_r) == cksum_r;
    status.status_zero  = status_seen_r == '0;
    status.cnt_zero     = count_r == '0;
    status.emit_last    = (idx_r + CNT_W'(1)) == count_r;
    status.out_free     = out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r      <= bsfp_pkg::START_RST;
      command_r    <= bsfp_pkg::COMMAND_RST;
      exp_status_r <= bsfp_pkg::STATUS_RST;
      plen_r       <= bsfp_pkg::LENGTH_RST;
      end_r        <= bsfp_pkg::END_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bsfp_pkg::CFG_START:   start_r      <= cfg_wdata;
        bsfp_pkg::CFG_COMMAND: command_r    <= cfg_wdata;
        bsfp_pkg::CFG_STATUS:  exp_status_r <= cfg_wdata;
        bsfp_pkg::CFG_LENGTH:  plen_r       <= cfg_wdata[bsfp_pkg::PLEN_W-1:0];
        bsfp_pkg::CFG_END:     end_r        <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.clr_count) begin
      count_nxt = '0;
    end else if (cmd.store_data) begin
      count_nxt = count_inc;
    end
  end

  always_comb begin
    sum_nxt = sum_r;
    if (cmd.cap_status) begin
      sum_nxt = bsfp_pkg::SUM_W'(rx_byte);
    end else if (cmd.add_sum) begin
      sum_nxt = sum_r + bsfp_pkg::SUM_W'(rx_byte);
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.start_emit) begin
      idx_nxt = '0;
    end else if (cmd.emit_load) begin
      idx_nxt = idx_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
      sum_r   <= '0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_status) begin
      status_seen_r <= rx_byte;
    end
    if (cmd.cap_ckhi) begin
      cksum_r[bsfp_pkg::SUM_W-1:bsfp_pkg::RX_W] <= rx_byte;
    end
    if (cmd.cap_cklo) begin
      cksum_r[bsfp_pkg::RX_W-1:0] <= rx_byte;
    end
  end

  bsfp_ram #(
    .WIDTH (bsfp_pkg::RX_W),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.store_data && room),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_data (rx_byte),
    .rd_en   (cmd.emit_rd),
    .rd_addr (idx_r[ADDR_W-1:0]),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_load || cmd.load_verdict) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_verdict) begin
      out_byte_r <= '0;
      out_idx_r  <= '0;
      out_fs_r   <= cmd.verdict;
      out_last_r <= 1'b1;
    end else if (cmd.emit_load) begin
      out_byte_r <= ram_rd_data;
      out_idx_r  <= bsfp_pkg::IDX_W'(idx_r);
      out_fs_r   <= bsfp_pkg::FS_OK;
      out_last_r <= status.emit_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_byte_r;
  assign out_byte_index   = out_idx_r;
  assign out_frame_status = out_fs_r;
  assign out_last         = out_last_r;

endmodule

// File: hw/rtl/bms_serial_frame_parser.sv
// Top level of the serial frame parser with sum checksum and end byte.
// Depends on bsfp_pkg, bsfp_if, bsfp_ctrl, bsfp_dp and the assertion header.
//
// Usage: received serial bytes enter on in_ch, one per transfer. The block
// hunts for the start, command, status and length bytes, stores the payload,
// takes a big-endian 16-bit checksum and checks the end byte. A good frame
// leaves on out_ch as its payload bytes in order, the final one marked with
// last. A bad end byte, a bad checksum or a nonzero device status each give
// a single verdict transfer with last set and a zero payload byte.
// Every byte of a frame up to the checksum is taken whenever it is valid.
// The end byte is taken once the result register is free; a verdict is
// visible in the cycle after the end byte's transfer. A good frame's payload
// then leaves byte by byte: each is read through the payload memory's
// registered read port (EMIT_RD), then loaded into the result register once
// it is free (EMIT_LD). No input is taken while the payload is read out.
// The cfg_ port writes the five header registers; writes are expected only
// while no frame result is pending. Reset returns the block to the start
// hunt, restores the register defaults and empties the result register. If
// the receiver stalls out_ch, the current result holds and the block stops
// taking the end byte of a frame or reading out more payload.
`include "bms_serial_frame_parser_assert.svh"
module bms_serial_frame_parser #(
  parameter int MAX_PAYLOAD = bsfp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  bsfp_in_if.sink                           in_ch,
  bsfp_out_if.source                        out_ch,
  input  logic                              cfg_wr_en,
  input  logic [bsfp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bsfp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  bsfp_pkg::ctrl_cmd_t  cmd;
  bsfp_pkg::dp_status_t status;
  logic                 in_ready;

  // The controller owns the frame phase and sequences the payload readout.
  bsfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds every register that a frame fills in.
  bsfp_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .rx_byte          (in_ch.rx_byte),
    .cmd              (cmd),
    .status           (status),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_payload_byte (out_ch.payload_byte),
    .out_byte_index   (out_ch.byte_index),
    .out_frame_status (out_ch.frame_status),
    .out_last         (out_ch.last)
  );

  assign in_ch.ready = in_ready;

  // A result may only be loaded when the result register is free.
  `BSFP_ASSERT_IMP(a_load_slot_free, clk, rst_n, (cmd.emit_load || cmd.load_verdict) |-> (!out_ch.valid || out_ch.ready), "result loaded over a pending result")
  // A verdict and a payload byte are never loaded in the same cycle.
  `BSFP_ASSERT_NEVER(a_single_load, clk, rst_n, cmd.emit_load && cmd.load_verdict, "verdict and payload loaded together")
  // No input byte is taken while the payload is being read out.
  `BSFP_ASSERT_NEVER(a_no_input_in_readout, clk, rst_n, (cmd.emit_load || cmd.emit_rd) && in_ch.valid && in_ch.ready, "input taken during readout")
  // An error verdict always closes the frame and carries a zero payload byte.
  `BSFP_ASSERT_IMP(a_verdict_shape, clk, rst_n, (out_ch.valid && (out_ch.frame_status != bsfp_pkg::FS_OK)) |-> (out_ch.last && (out_ch.payload_byte == '0)), "malformed verdict")

endmodule
